// ===== rtl/core/gamepad_frame_deframer_crc16_assert.svh =====
// ----------------------------------------------------------------------------
// gamepad_frame_deframer_crc16 assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define GAMEPAD_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// same-cycle implication
`define GFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gfd_pkg.sv =====
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared constants and types for the gamepad frame deframer.
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int MAX_FRAME_BYTES = 16;
  localparam int MIN_FRAME_BYTES = 13;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

  // frame byte positions
  localparam int LAST_CRC_BYTE   = 10;
  localparam int CRC_HI_BYTE     = 11;
  localparam int CRC_LO_BYTE     = 12;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_BYTE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd50;
  localparam logic [7:0]  START_BYTE_RST   = 8'h0A;
  localparam logic [4:0]  FRAME_LENGTH_RST = 5'd15;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] IDLE_SAT = 16'hFFFF;

  localparam int OUT_TDATA_W = 104;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [7:0]         right_trigger;
    logic [7:0]         left_trigger;
    logic [7:0]         buttons_second;
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic [7:0]         buttons_first;
    logic               crc_ok;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== rtl/core/gfd_crc_step.sv =====
// ----------------------------------------------------------------------------
// gfd_crc_step
// One byte of CRC-16/CCITT-FALSE, msb first, unrolled over the eight bits.
// ----------------------------------------------------------------------------
module gfd_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ gfd_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== rtl/core/gfd_frame_parse.sv =====
// ----------------------------------------------------------------------------
// gfd_frame_parse
// Idle timer, frame collection, CRC check and field unpacking, one item
// per cycle.
// ----------------------------------------------------------------------------
`include "gamepad_frame_deframer_crc16_assert.svh"

module gfd_frame_parse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                item_valid,
  input  logic                                item_op,
  input  logic [7:0]                          item_byte,
  output logic                                res_valid,
  output gfd_pkg::result_t                    res
);

  logic [15:0]                   idle_timeout_r;
  logic [7:0]                    start_byte_r;
  logic [4:0]                    frame_length_r;

  logic [gfd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [15:0]                   idle_r, idle_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic [63:0]                   sticks_r, sticks_nxt;
  logic [31:0]                   btn_r, btn_nxt;
  logic [7:0]                    store_r [gfd_pkg::MAX_FRAME_BYTES];

  logic [gfd_pkg::LEN_W-1:0]     len_eff;
  logic [gfd_pkg::POS_W-1:0]     pos_start;
  logic [gfd_pkg::POS_W-1:0]     pos_eff;
  logic [gfd_pkg::LEN_W-1:0]     pos_inc;
  logic                          byte_go;
  logic                          discard;
  logic                          done;
  logic                          crc_ok;
  logic                          store_we;
  logic [15:0]                   crc_step;
  logic [7:0]                    fb [gfd_pkg::CRC_LO_BYTE + 1];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= gfd_pkg::IDLE_TIMEOUT_RST;
      start_byte_r   <= gfd_pkg::START_BYTE_RST;
      frame_length_r <= gfd_pkg::FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gfd_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        gfd_pkg::REG_START_BYTE:   start_byte_r   <= cfg_wdata[7:0];
        gfd_pkg::REG_FRAME_LENGTH: frame_length_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  gfd_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (item_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    if (gfd_pkg::LEN_W'(frame_length_r) < gfd_pkg::LEN_W'(gfd_pkg::MIN_FRAME_BYTES)) begin
      len_eff = gfd_pkg::LEN_W'(gfd_pkg::MIN_FRAME_BYTES);
    end else if (gfd_pkg::LEN_W'(frame_length_r) >
                 gfd_pkg::LEN_W'(gfd_pkg::MAX_FRAME_BYTES)) begin
      len_eff = gfd_pkg::LEN_W'(gfd_pkg::MAX_FRAME_BYTES);
    end else begin
      len_eff = gfd_pkg::LEN_W'(frame_length_r);
    end
  end

  always_comb begin
    byte_go   = item_valid && (item_op == gfd_pkg::OP_BYTE);
    // long silence restarts the frame
    pos_start = (idle_r > idle_timeout_r) ? '0 : pos_r;
    discard   = (pos_start == '0) && (item_byte != start_byte_r);
    // length shrunk under a partial frame: fall back to position zero
    pos_eff   = (gfd_pkg::LEN_W'(pos_start) >= len_eff) ? '0 : pos_start;
    pos_inc   = gfd_pkg::LEN_W'(pos_eff) + gfd_pkg::LEN_W'(1);
    done      = (pos_inc >= len_eff);
    store_we  = byte_go && !discard;

    if (pos_eff == '0) begin
      crc_nxt = gfd_pkg::CRC_INIT;
    end else if (gfd_pkg::LEN_W'(pos_eff) <= gfd_pkg::LEN_W'(gfd_pkg::LAST_CRC_BYTE)) begin
      crc_nxt = crc_step;
    end else begin
      crc_nxt = crc_r;
    end

    // frame bytes with the byte now arriving bypassed in
    for (int k = 0; k <= gfd_pkg::CRC_LO_BYTE; k++) begin
      fb[k] = (pos_eff == gfd_pkg::POS_W'(k)) ? item_byte : store_r[k];
    end

    crc_ok = (crc_nxt == {fb[gfd_pkg::CRC_HI_BYTE], fb[gfd_pkg::CRC_LO_BYTE]});

    if (crc_ok) begin
      sticks_nxt = {fb[8], fb[9], fb[6], fb[7], fb[4], fb[5], fb[2], fb[3]};
      btn_nxt    = {fb[12], fb[11], fb[10], fb[1]};
    end else begin
      sticks_nxt = sticks_r;
      btn_nxt    = btn_r;
    end

    if (item_valid && (item_op == gfd_pkg::OP_TICK)) begin
      idle_nxt = (idle_r == gfd_pkg::IDLE_SAT) ? idle_r : idle_r + 16'd1;
    end else if (byte_go) begin
      idle_nxt = '0;
    end else begin
      idle_nxt = idle_r;
    end

    if (store_we) begin
      pos_nxt = done ? '0 : pos_inc[gfd_pkg::POS_W-1:0];
    end else if (byte_go) begin
      pos_nxt = pos_start;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      idle_r   <= gfd_pkg::IDLE_SAT;
      crc_r    <= gfd_pkg::CRC_INIT;
      sticks_r <= '0;
      btn_r    <= '0;
    end else begin
      pos_r  <= pos_nxt;
      idle_r <= idle_nxt;
      if (store_we) begin
        crc_r <= crc_nxt;
      end
      if (store_we && done) begin
        sticks_r <= sticks_nxt;
        btn_r    <= btn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_eff] <= item_byte;
    end
  end

  always_comb begin
    res_valid          = store_we && done;
    res.crc_ok         = crc_ok;
    res.buttons_first  = btn_nxt[7:0];
    res.left_x         = sticks_nxt[15:0];
    res.left_y         = sticks_nxt[31:16];
    res.right_x        = sticks_nxt[47:32];
    res.right_y        = sticks_nxt[63:48];
    res.buttons_second = btn_nxt[15:8];
    res.left_trigger   = btn_nxt[23:16];
    res.right_trigger  = btn_nxt[31:24];
  end

  `GFD_ASSERT_NEXT(a_frame_end_rewinds, res_valid, pos_r == '0, "position not rewound after frame")
  `GFD_ASSERT_NEXT(a_byte_clears_idle, byte_go, idle_r == '0, "idle count not cleared by byte")
  `GFD_ASSERT_NEXT(a_idle_saturates, item_valid && (item_op == gfd_pkg::OP_TICK) && (idle_r == gfd_pkg::IDLE_SAT), idle_r == gfd_pkg::IDLE_SAT, "idle count wrapped")
  `GFD_ASSERT_NEXT(a_bad_crc_holds, res_valid && !res.crc_ok, $stable(sticks_r) && $stable(btn_r), "last good fields changed on CRC error")

endmodule

// ===== rtl/core/gfd_out_skid.sv =====
// ----------------------------------------------------------------------------
// gfd_out_skid
// Result register with a skid stage; ready towards the parser is registered.
// ----------------------------------------------------------------------------
`include "gamepad_frame_deframer_crc16_assert.svh"

module gfd_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gfd_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output gfd_pkg::result_t out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  gfd_pkg::result_t main_r, main_nxt;
  gfd_pkg::result_t skid_r, skid_nxt;
  logic             main_free;

  always_comb begin
    main_free      = !main_valid_r || out_ready;
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      // receiver stalled: park the transfer
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  `GFD_ASSERT_SAME(a_skid_behind_main, skid_valid_r, main_valid_r, "skid holds data while output empty")
  `GFD_ASSERT_SAME(a_no_push_when_full, push, !skid_valid_r, "result pushed into full buffer")
  `GFD_ASSERT_NEXT(a_stall_parks, push && main_valid_r && !out_ready, skid_valid_r, "stalled result not parked")

endmodule

// ===== rtl/core/gamepad_frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// gamepad_frame_deframer_crc16
// Gamepad serial frame deframer with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Input stream: in_tuser = 0 carries a received byte in in_tdata, in_tuser = 1
// is a one millisecond tick. One transfer is taken every cycle while in_tready
// is high. A byte after more than idle_timeout_ms ticks restarts the frame;
// frames open with start_byte and end after frame_length bytes (13..16).
// Output stream: one transfer per completed frame carrying crc_ok and the
// unpacked fields; on a CRC error the last good fields are repeated.
// The result of a frame's last byte goes straight into the result register,
// or the skid entry on a stall. Throughput: one item per cycle while in_tready
// is high, set by the single bytewise CRC step and field capture.
// Stall: a result register plus one skid entry; in_tready drops only when
// both are full, and returns the cycle after the receiver takes a transfer.
// Reset (synchronous, rst_n low): registers back to their defaults, position
// zero, idle count saturated, last good fields zero, output empty.
// Configuration: cfg_we writes register cfg_addr (0 idle timeout, 1 start
// byte, 2 frame length) at the clock edge; write only while idle.
// ----------------------------------------------------------------------------
module gamepad_frame_deframer_crc16 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [gfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] crc_ok, [8:1] buttons_first, [24:9] left_x, [40:25] left_y,
  // [56:41] right_x, [72:57] right_y, [80:73] buttons_second,
  // [88:81] left_trigger, [96:89] right_trigger, [103:97] zero
  output logic [gfd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic             item_valid;
  logic             res_valid;
  logic             space;
  gfd_pkg::result_t res;
  gfd_pkg::result_t out_res;

  assign in_tready  = space;
  assign item_valid = in_tvalid && in_tready;

  gfd_frame_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_op    (in_tuser),
    .item_byte  (in_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  gfd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {(gfd_pkg::OUT_TDATA_W - gfd_pkg::RESULT_W)'(0), out_res};

endmodule
